FILE: design/slewed_time_anchor_tracker_core_assert.svh
// assertion macros shared by the tracker's checker
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef SLEWED_TIME_ANCHOR_TRACKER_CORE_ASSERT_SVH
`define SLEWED_TIME_ANCHOR_TRACKER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define STAT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tracker assertion failed");

// next-cycle implication, off during reset
`define STAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tracker assertion failed");

// next-cycle implication that also holds across reset
`define STAT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tracker assertion failed");

`endif

FILE: design/stat_pkg.sv
// shared codes and fixed widths for the slewed time anchor tracker
// no dependencies; used by the input channel interface and the core
package stat_pkg;

  // item mode field
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_SET    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SYNC   = 2'd2;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN   = 1'd1;

  // register widths
  localparam int THRESH_W   = 47;
  localparam int GAIN_W     = 17;
  localparam int CFG_DATA_W = 47;

  // gain is q1.16, clamped to one
  localparam int GAIN_FRAC = 16;
  localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd6554;

  // default resync threshold in whole milliseconds
  localparam int RESYNC_MS = 150;

endpackage

FILE: design/stat_in_if.sv
// input channel of the tracker: valid/ready with mode and two times
// depends on stat_pkg for the mode width
interface stat_in_if #(
  parameter int TIME_BITS = 48
);
  logic                             valid;
  logic                             ready;
  logic [stat_pkg::MODE_W-1:0]      mode;
  logic signed [TIME_BITS-1:0]      wall_time;
  logic signed [TIME_BITS-1:0]      reference_time;

  modport source (output valid, mode, wall_time, reference_time, input ready);
  modport sink (input valid, mode, wall_time, reference_time, output ready);
endinterface

FILE: design/stat_out_if.sv
// result channel of the tracker: valid/ready with the sampled game time
// no dependencies
interface stat_out_if #(
  parameter int TIME_BITS = 48
);
  logic                        valid;
  logic                        ready;
  logic signed [TIME_BITS-1:0] game_time;

  modport source (output valid, game_time, input ready);
  modport sink (input valid, game_time, output ready);
endinterface

FILE: design/slewed_time_anchor_tracker_core.sv
// path: a sample item passes the input register, then the result register
// throughput: one item per cycle unless results stall; the anchor loop (project,
//   error, slew multiply, saturating add) is combinational behind the input register
// reset: synchronous, active high; anchor cleared to zero, last output to the most
//   negative time, threshold to 150 ms and gain to 0.1; no clearing pass
// depends on stat_pkg, stat_in_if and stat_out_if
module slewed_time_anchor_tracker_core #(
  parameter int TIME_BITS = 48,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  stat_in_if.sink                             items,
  stat_out_if.source                          results,
  input  logic                                cfg_we,
  input  logic [stat_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [stat_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int TW   = stat_pkg::THRESH_W;
  localparam int GW   = stat_pkg::GAIN_W;
  localparam int CW   = (TIME_BITS > TW) ? TIME_BITS : TW;  // magnitude compare width
  localparam int PW   = TIME_BITS + GW + 1;                 // signed product width
  localparam logic signed [TIME_BITS-1:0] TMIN = {1'b1, {(TIME_BITS-1){1'b0}}};
  localparam logic signed [TIME_BITS-1:0] TMAX = {1'b0, {(TIME_BITS-1){1'b1}}};
  localparam logic [TW-1:0] THRESH_RESET = TW'(stat_pkg::RESYNC_MS) << FRAC_BITS;

  // saturating add and subtract on the time format
  function automatic logic signed [TIME_BITS-1:0] sat_add(
    input logic signed [TIME_BITS-1:0] a,
    input logic signed [TIME_BITS-1:0] b
  );
    logic [TIME_BITS:0] s;
    s = {a[TIME_BITS-1], a} + {b[TIME_BITS-1], b};
    if (s[TIME_BITS] != s[TIME_BITS-1]) begin
      return s[TIME_BITS] ? TMIN : TMAX;
    end
    return s[TIME_BITS-1:0];
  endfunction

  function automatic logic signed [TIME_BITS-1:0] sat_sub(
    input logic signed [TIME_BITS-1:0] a,
    input logic signed [TIME_BITS-1:0] b
  );
    logic [TIME_BITS:0] s;
    s = {a[TIME_BITS-1], a} - {b[TIME_BITS-1], b};
    if (s[TIME_BITS] != s[TIME_BITS-1]) begin
      return s[TIME_BITS] ? TMIN : TMAX;
    end
    return s[TIME_BITS-1:0];
  endfunction

  // configuration registers
  logic [TW-1:0] resync_threshold;
  logic [GW-1:0] slew_gain;

  // tracker state
  logic signed [TIME_BITS-1:0] anchor_wall;
  logic signed [TIME_BITS-1:0] anchor_game;
  logic signed [TIME_BITS-1:0] last_output;

  // input register
  logic                           s_valid;
  logic [stat_pkg::MODE_W-1:0]    s_mode;
  logic signed [TIME_BITS-1:0]    s_wall;
  logic signed [TIME_BITS-1:0]    s_ref;

  // result register
  logic                           out_valid;
  logic signed [TIME_BITS-1:0]    out_time;

  // handshake control
  logic in_xfer;
  logic out_free;
  logic s_adv;
  logic s_is_sample;

  // datapath
  logic signed [TIME_BITS-1:0] wall_delta;
  logic signed [TIME_BITS-1:0] proj;
  logic signed [TIME_BITS-1:0] err;
  logic [TIME_BITS-1:0]        err_mag;
  logic                        snap;
  logic [GW-1:0]               gain_c;
  logic signed [PW-1:0]        prod;
  logic signed [TIME_BITS-1:0] slew;
  logic signed [TIME_BITS-1:0] slewed_game;
  logic signed [TIME_BITS-1:0] sample_time;

  // the stage moves on unless a sample result has nowhere to go
  assign out_free    = !out_valid || results.ready;
  assign s_is_sample = (s_mode == stat_pkg::MODE_SAMPLE);
  assign s_adv       = s_valid && (!s_is_sample || out_free);
  assign items.ready = !s_valid || s_adv;
  assign in_xfer     = items.valid && items.ready;

  assign results.valid     = out_valid;
  assign results.game_time = out_time;

  // extrapolation from the anchor
  assign wall_delta = sat_sub(s_wall, anchor_wall);
  assign proj       = sat_add(anchor_game, wall_delta);

  // output never falls below the last one given
  assign sample_time = (proj < last_output) ? last_output : proj;

  // sync error against the measured reference; the most negative error has
  // magnitude 2^(TIME_BITS-1), which still fits unsigned
  assign err     = sat_sub(s_ref, proj);
  assign err_mag = err[TIME_BITS-1] ? (~err + 1'b1) : err;
  assign snap    = CW'(err_mag) > CW'(resync_threshold);

  // gain above one acts as one
  assign gain_c = (slew_gain > stat_pkg::GAIN_ONE) ? stat_pkg::GAIN_ONE : slew_gain;

  // arithmetic shift floors towards minus infinity; |slew| <= |err| so it fits
  assign prod        = PW'(err) * $signed({1'b0, gain_c});
  assign slew        = TIME_BITS'(prod >>> stat_pkg::GAIN_FRAC);
  assign slewed_game = sat_add(proj, slew);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      resync_threshold <= THRESH_RESET;
      slew_gain        <= stat_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        stat_pkg::CFG_THRESH: resync_threshold <= cfg_wdata[TW-1:0];
        stat_pkg::CFG_GAIN:   slew_gain        <= cfg_wdata[GW-1:0];
        default: ;
      endcase
    end
  end

  // input register: takes a transfer when empty or when the held item leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_xfer) begin
      s_valid <= 1'b1;
    end else if (s_adv) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s_mode <= items.mode;
      s_wall <= items.wall_time;
      s_ref  <= items.reference_time;
    end
  end

  // anchor and last output follow each item as it leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_wall <= '0;
      anchor_game <= '0;
      last_output <= TMIN;
    end else if (s_adv) begin
      case (s_mode)
        stat_pkg::MODE_SET: begin
          anchor_wall <= s_wall;
          anchor_game <= s_ref;
          last_output <= s_ref;
        end
        stat_pkg::MODE_SAMPLE: begin
          last_output <= sample_time;
        end
        stat_pkg::MODE_SYNC: begin
          anchor_wall <= s_wall;
          anchor_game <= snap ? s_ref : slewed_game;
        end
        default: ;
      endcase
    end
  end

  // result register, loaded only by samples
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_adv && s_is_sample) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv && s_is_sample) begin
      out_time <= sample_time;
    end
  end

endmodule

FILE: design/stat_checker.sv
// port-level checks for the tracker, bound into the tracker core
// depends on stat_pkg and the assertion macro header
`include "slewed_time_anchor_tracker_core_assert.svh"

module stat_checker #(
  parameter int TIME_BITS = 48
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [stat_pkg::MODE_W-1:0]       in_mode,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [TIME_BITS-1:0]       game_time
);

  logic                        in_xfer;
  logic                        out_xfer;
  logic                        sample_in;
  logic                        set_in;
  logic [1:0]                  pend;
  logic [1:0]                  pend_next;
  logic                        dirty;
  logic                        post;
  logic                        have_prev;
  logic signed [TIME_BITS-1:0] prev_time;

  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign sample_in = in_xfer && (in_mode == stat_pkg::MODE_SAMPLE);
  assign set_in    = in_xfer && (in_mode == stat_pkg::MODE_SET);
  assign pend_next = pend + {1'b0, sample_in} - {1'b0, out_xfer};

  // samples in flight, and whether a set-anchor may have lowered the floor
  // post: a sample has been taken since the latest set-anchor
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      dirty     <= 1'b0;
      post      <= 1'b0;
      have_prev <= 1'b0;
    end else begin
      pend <= pend_next;
      if (set_in) begin
        post <= 1'b0;
      end else if (sample_in) begin
        post <= 1'b1;
      end
      if (set_in) begin
        dirty <= 1'b1;
      end else if (out_xfer && pend == 2'd1 && !in_xfer && post) begin
        dirty <= 1'b0;
      end
      if (out_xfer) begin
        have_prev <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      prev_time <= game_time;
    end
  end

  `STAT_ASSERT_NOW(a_result_has_sample, clk, rst, out_xfer, pend != 2'd0)
  `STAT_ASSERT_NOW(a_monotonic, clk, rst, out_xfer && have_prev && !dirty, game_time >= prev_time)
  `STAT_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)
  `STAT_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(game_time))

endmodule

bind slewed_time_anchor_tracker_core stat_checker #(
  .TIME_BITS(TIME_BITS)
) u_stat_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .in_mode   (items.mode),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .game_time (results.game_time)
);

FILE: sim/stat_timeline_checker.sv
// scoreboard for the slewed time anchor tracker: tracks anchor, clamp and registers
// and checks every sampled game time in order; depends on stat_pkg and both channel
// interfaces
module stat_timeline_checker #(
  parameter int TIME_BITS = 48,
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  stat_in_if                               items,
  stat_out_if                              results,
  input  logic                             cfg_we,
  input  logic [stat_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [stat_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                               mismatch_count,
  output int                               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import stat_pkg::*;

  typedef logic signed [TIME_BITS-1:0] stamp_t;
  typedef logic signed [TIME_BITS+1:0] wide_t;

  localparam stamp_t STAMP_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};
  localparam stamp_t STAMP_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};

  logic [THRESH_W-1:0] resync_limit;
  logic [GAIN_W-1:0]   slew_frac;
  stamp_t              anchor_wall_q;
  stamp_t              anchor_game_q;
  stamp_t              last_given;
  stamp_t              due_game_times[$];

  function automatic wide_t widen(stamp_t t);
    wide_t w;
    w = t;
    return w;
  endfunction

  // clip a widened sum back into the time range
  function automatic stamp_t saturate(wide_t v);
    if (v[TIME_BITS+1:TIME_BITS-1] == 3'b000 || v[TIME_BITS+1:TIME_BITS-1] == 3'b111)
      return v[TIME_BITS-1:0];
    return v[TIME_BITS+1] ? STAMP_MIN : STAMP_MAX;
  endfunction

  function automatic stamp_t extrapolate(stamp_t wall);
    return saturate(widen(anchor_game_q) + widen(saturate(widen(wall) - widen(anchor_wall_q))));
  endfunction

  task automatic advance_timeline(logic [MODE_W-1:0] mode, stamp_t wall, stamp_t ref_time);
    stamp_t                         t;
    stamp_t                         err;
    wide_t                          err_w;
    wide_t                          slew;
    logic [TIME_BITS+1:0]           err_mag;
    logic [GAIN_W-1:0]              g;
    logic signed [TIME_BITS+GAIN_W:0] prod;
    case (mode)
      MODE_SET: begin
        anchor_wall_q = wall;
        anchor_game_q = ref_time;
        last_given    = ref_time;
      end
      MODE_SAMPLE: begin
        t = extrapolate(wall);
        if (t < last_given) t = last_given;
        else last_given = t;
        due_game_times.push_back(t);
      end
      MODE_SYNC: begin
        t       = extrapolate(wall);
        err     = saturate(widen(ref_time) - widen(t));
        err_w   = widen(err);
        err_mag = err_w[TIME_BITS+1] ? -err_w : err_w;
        anchor_wall_q = wall;
        if (err_mag > (TIME_BITS+2)'(resync_limit)) begin
          anchor_game_q = ref_time;
        end else begin
          g    = (slew_frac > GAIN_ONE) ? GAIN_ONE : slew_frac;
          prod = err_w * $signed({1'b0, g});
          // arithmetic shift floors towards minus infinity
          slew = wide_t'(prod >>> GAIN_FRAC);
          anchor_game_q = saturate(widen(t) + slew);
        end
      end
      default: ;
    endcase
  endtask

  // sampled mid-cycle, where both channels are settled for the coming edge
  always @(negedge clk) begin
    stamp_t want;
    if (rst) begin
      resync_limit  = THRESH_W'(RESYNC_MS) << FRAC_BITS;
      slew_frac     = GAIN_RESET;
      anchor_wall_q = '0;
      anchor_game_q = '0;
      last_given    = STAMP_MIN;
      due_game_times.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESH: resync_limit = cfg_wdata[THRESH_W-1:0];
          CFG_GAIN:   slew_frac    = cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        if (due_game_times.size() == 0) begin
          $display("%0t ns: unexpected game_time, expected none, got %0d",
                   $time, results.game_time);
          mismatch_count++;
        end else begin
          want = due_game_times.pop_front();
          if (want !== results.game_time) begin
            $display("%0t ns: game_time expected %0d, got %0d",
                     $time, want, results.game_time);
            mismatch_count++;
          end
        end
      end
      if (items.valid && items.ready)
        advance_timeline(items.mode, items.wall_time, items.reference_time);
    end
    outstanding = due_game_times.size();
  end

endmodule

FILE: sim/tb_slewed_time_anchor_tracker_core.sv
// top of the tracker testbench: clock, reset, register writes and item stimulus
// depends on stat_pkg, stat_in_if, stat_out_if, the core and stat_timeline_checker
module tb_slewed_time_anchor_tracker_core;
  timeunit 1ns;
  timeprecision 1ps;
  import stat_pkg::*;

  localparam int TIME_BITS = 48;
  localparam int FRAC_BITS = 16;

  // one millisecond in q31.16, and the ends of the time range
  localparam longint MS         = 64'sd65536;
  localparam longint T_MAX      = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint T_MIN      = -T_MAX - 1;
  localparam longint THRESH_TOP = 64'sh0000_7FFF_FFFF_FFFF;

  // mode value the block must ignore
  localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;
  localparam logic [GAIN_W-1:0] GAIN_ALL_ONES = '1;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 56;

  // receiver behaviours
  localparam int SINK_OPEN     = 0;
  localparam int SINK_PATTERN  = 1;
  localparam int SINK_RANDOM   = 2;
  localparam int SINK_SLUGGISH = 3;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic [MODE_W-1:0]      in_mode   = MODE_SET;
  logic [TIME_BITS-1:0]   in_wall   = '0;
  logic [TIME_BITS-1:0]   in_ref    = '0;
  logic                   out_ready = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_THRESH;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int          sink_style    = SINK_PATTERN;
  logic [15:0] stall_mask    = 16'hB3C5;
  int          cycles        = 0;
  int          burst_left    = 0;
  int          items_sent    = 0;
  bit          steady_sender = 1'b0;
  longint      cur_thr;
  int          mismatch_count;
  int          outstanding;

  stat_in_if  #(.TIME_BITS(TIME_BITS)) items_ch ();
  stat_out_if #(.TIME_BITS(TIME_BITS)) results_ch ();

  assign items_ch.valid          = in_valid;
  assign items_ch.mode           = in_mode;
  assign items_ch.wall_time      = in_wall;
  assign items_ch.reference_time = in_ref;
  assign results_ch.ready        = out_ready;

  slewed_time_anchor_tracker_core #(
    .TIME_BITS(TIME_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .items     (items_ch),
    .results   (results_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  stat_timeline_checker #(
    .TIME_BITS(TIME_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) watch (
    .clk            (clk),
    .rst            (rst),
    .items          (items_ch),
    .results        (results_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: its own stall behaviour, independent of the sender's bursts
  always @(posedge clk) begin
    stall_mask <= {stall_mask[14:0], stall_mask[15]};
    case (sink_style)
      SINK_OPEN:    out_ready <= 1'b1;
      SINK_PATTERN: out_ready <= stall_mask[15];
      SINK_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
      default:      out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  function automatic longint rand_word();
    longint unsigned r;
    r = {$urandom, $urandom};
    return longint'(r);
  endfunction

  // uniform in [0, n), n positive
  function automatic longint rand_below(longint n);
    longint unsigned r;
    r = {$urandom, $urandom};
    return longint'(r % longint'(n));
  endfunction

  // uniform in [-span, span]
  function automatic longint rand_signed(longint span);
    return rand_below(2 * span + 1) - span;
  endfunction

  // sender bursts: a random gap opens before each burst, unless the phase keeps it steady
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      repeat (gap) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // present one item and hold it until the transfer; ready is read mid-cycle
  task automatic push_item(logic [MODE_W-1:0] mode, longint wall, longint ref_time);
    bit taken;
    pace();
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_wall  <= wall[TIME_BITS-1:0];
    in_ref   <= ref_time[TIME_BITS-1:0];
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = items_ch.ready;
      @(posedge clk);
    end
    items_sent++;
  endtask

  // registers change only with the block idle: drain results, then let the pipe empty
  task automatic program_regs(longint thr, logic [GAIN_W-1:0] gain);
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_THRESH;
    cfg_wdata <= thr[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_GAIN;
    cfg_wdata <= CFG_DATA_W'(gain);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_thr = thr;
  endtask

  // one anchored run: set the anchor, then walk wall time forwards with samples and
  // syncs whose measurement sits near the anchored line, plus the odd stray item
  task automatic random_stretch();
    longint base_wall;
    longint base_ref;
    longint wall;
    longint span;
    int     len;
    int     pick;
    if ($urandom_range(0, 7) == 0) begin
      // close to an end of the range, so extrapolation and error saturate
      base_wall = $urandom_range(0, 1) ? T_MAX - rand_below(64'sd1 <<< 30)
                                       : T_MIN + rand_below(64'sd1 <<< 30);
      base_ref  = $urandom_range(0, 1) ? T_MAX - rand_below(64'sd1 <<< 30)
                                       : T_MIN + rand_below(64'sd1 <<< 30);
    end else begin
      base_wall = rand_signed(64'sd1 <<< 44);
      base_ref  = rand_signed(64'sd1 <<< 44);
    end
    push_item(MODE_SET, base_wall, base_ref);
    wall = base_wall;
    len  = $urandom_range(4, 24);
    // jitter straddles the threshold so both snap and slew happen
    span = (cur_thr > (64'sd1 <<< 40)) ? (64'sd1 <<< 40) : cur_thr + cur_thr / 2 + 8;
    repeat (len) begin
      wall += rand_below(64'sd1 <<< 20);
      pick = $urandom_range(0, 9);
      if (pick < 5)
        push_item(MODE_SAMPLE, wall, rand_word());
      else if (pick < 8)
        push_item(MODE_SYNC, wall, base_ref + (wall - base_wall) + rand_signed(span));
      else if (pick == 8)
        // re-anchor a little behind, pulling the last output back
        push_item(MODE_SET, wall, base_ref + (wall - base_wall) - rand_below(span));
      else
        push_item(MODE_W'($urandom_range(int'(MODE_SET), int'(MODE_SPARE))),
                  rand_word(), rand_word());
    end
  endtask

  initial begin
    longint            thr;
    logic [GAIN_W-1:0] gain;
    int                phase_start;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    cur_thr = longint'(RESYNC_MS) * MS;

    // directed, on the reset register values
    push_item(MODE_SAMPLE, 0, 0);                 // first sample after reset
    push_item(MODE_SAMPLE, T_MIN, 12345);         // behind the last output, held
    push_item(MODE_SET, T_MAX, T_MIN);
    push_item(MODE_SAMPLE, T_MIN, 0);             // both sums saturate low
    push_item(MODE_SET, T_MIN, T_MAX);
    push_item(MODE_SAMPLE, T_MAX, 0);             // both sums saturate high
    push_item(MODE_SET, 0, 1000 * MS);            // last output moves backwards
    push_item(MODE_SAMPLE, 10 * MS, 0);
    push_item(MODE_SYNC, 20 * MS, 1070 * MS);     // positive error, slewed in
    push_item(MODE_SAMPLE, 21 * MS, 0);
    push_item(MODE_SET, 100 * MS, 5000 * MS);
    push_item(MODE_SYNC, 100 * MS, 5000 * MS - 7); // small negative error floors to -1
    push_item(MODE_SAMPLE, 101 * MS, 0);
    push_item(MODE_SET, 0, 0);
    push_item(MODE_SYNC, 0, 150 * MS);            // error exactly on the threshold
    push_item(MODE_SET, 0, 0);
    push_item(MODE_SYNC, 0, -150 * MS - 1);       // one past the threshold, snaps
    push_item(MODE_SAMPLE, 0, 0);                 // snapped behind, held
    push_item(MODE_SET, T_MAX, T_MAX);
    push_item(MODE_SYNC, T_MIN, T_MAX);           // error saturates, snaps
    push_item(MODE_SPARE, 5 * MS, 7 * MS);        // unused mode, no effect
    push_item(MODE_SAMPLE, T_MIN + 1, 0);

    // gain register above one is clipped to one
    program_regs(THRESH_TOP, GAIN_ALL_ONES);
    push_item(MODE_SET, 0, 0);
    push_item(MODE_SYNC, 0, 1000);
    push_item(MODE_SAMPLE, 0, 0);

    // random phases, each on its own register setting and handshake style
    for (int phase = 0; phase < 6; phase++) begin
      steady_sender = 1'b0;
      case (phase)
        0: begin
          thr = longint'(RESYNC_MS) * MS;
          gain = GAIN_RESET;
          sink_style <= SINK_RANDOM;
        end
        1: begin
          thr = 0;
          gain = '0;
          sink_style <= SINK_SLUGGISH;
        end
        2: begin
          thr = THRESH_TOP;
          gain = GAIN_ONE;
          sink_style <= SINK_OPEN;
          steady_sender = 1'b1;
        end
        3: begin
          thr = $urandom_range(1, 1 << 20);
          gain = GAIN_ALL_ONES;
          sink_style <= SINK_PATTERN;
        end
        4: begin
          thr = rand_below(64'sd1 <<< 40);
          gain = GAIN_W'($urandom_range(0, (1 << GAIN_W) - 1));
          sink_style <= SINK_RANDOM;
        end
        default: begin
          thr = $urandom_range(1, 1 << 24);
          gain = GAIN_ONE - 1'b1;
          sink_style <= SINK_OPEN;
        end
      endcase
      program_regs(thr, gain);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) random_stretch();
    end

    // drain, then allow the pipe to settle before the verdict
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
